[hw/rtl/frl_pkg.sv]
package frl_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int FIELD_W    = 16;
  localparam int COS_W      = FRAC_BITS + 1;
  localparam int RATIO_BITS = 15;

  localparam logic [2*FRAC_BITS:0] ONE2      = (2*FRAC_BITS+1)'(1) << (2*FRAC_BITS);
  localparam logic [FIELD_W-1:0]   REFL_ONE  = FIELD_W'(1) << RATIO_BITS;
  localparam logic [FIELD_W-1:0]   INDEX_MAX = '1;

  typedef struct packed {
    logic signed [FIELD_W-1:0] normal_x;
    logic signed [FIELD_W-1:0] normal_y;
    logic signed [FIELD_W-1:0] normal_z;
    logic signed [FIELD_W-1:0] dir_x;
    logic signed [FIELD_W-1:0] dir_y;
    logic signed [FIELD_W-1:0] dir_z;
    logic        [FIELD_W-1:0] index_object;
    logic        [FIELD_W-1:0] index_surround;
  } frl_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] reflectance;
    logic [FIELD_W-1:0] relative_index;
    logic               total_reflection;
  } frl_out_t;

endpackage

[hw/rtl/frl_div.sv]
module frl_div #(
  parameter int NUM_W  = 31,
  parameter int DEN_W  = 16,
  parameter int Q_W    = 16,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [Q_W-1:0]    quot_o,
  output logic [SIDE_W-1:0] side_o
);

  // The caller guarantees num_i < den_i << Q_W, so Q_W restoring steps suffice.
  localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic              v_q    [Q_W];
  logic [W-1:0]      rem_q  [Q_W];
  logic [DEN_W-1:0]  den_q  [Q_W];
  logic [Q_W-1:0]    quot_q [Q_W];
  logic [SIDE_W-1:0] side_q [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    localparam int K = Q_W - 1 - i;
    logic              v_in;
    logic [W-1:0]      rem_in;
    logic [DEN_W-1:0]  den_in;
    logic [Q_W-1:0]    quot_in;
    logic [SIDE_W-1:0] side_in;
    logic [W:0]        diff;

    if (i == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = W'(num_i);
      assign den_in  = den_i;
      assign quot_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign den_in  = den_q[i-1];
      assign quot_in = quot_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign diff = {1'b0, rem_in} - {1'b0, W'(den_in) << K};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= diff[W] ? rem_in : diff[W-1:0];
        quot_q[i] <= {quot_in[Q_W-2:0], ~diff[W]};
        den_q[i]  <= den_in;
        side_q[i] <= side_in;
      end
    end
  end

  assign valid_o = v_q[Q_W-1];
  assign quot_o  = quot_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];

endmodule

[hw/rtl/frl_sqrt.sv]
module frl_sqrt #(
  parameter int R_W    = 15,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [2*R_W-2:0]  arg_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [R_W-1:0]    root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int W = 2 * R_W + 1;

  logic              v_q    [R_W];
  logic [W-1:0]      rem_q  [R_W];
  logic [R_W-1:0]    root_q [R_W];
  logic [SIDE_W-1:0] side_q [R_W];

  // One result bit per stage. The remainder holds arg - root^2, and setting bit B
  // adds (root << (B+1)) + (1 << 2B) to the square.
  for (genvar i = 0; i < R_W; i++) begin : g_stage
    localparam int B = R_W - 1 - i;
    logic              v_in;
    logic [W-1:0]      rem_in;
    logic [R_W-1:0]    root_in;
    logic [SIDE_W-1:0] side_in;
    logic [W-1:0]      trial;
    logic [W:0]        diff;

    if (i == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = W'(arg_i);
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign trial = (W'(root_in) << (B + 1)) + (W'(1) << (2 * B));
    assign diff  = {1'b0, rem_in} - {1'b0, trial};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= diff[W] ? rem_in : diff[W-1:0];
        root_q[i] <= diff[W] ? root_in : (root_in | (R_W'(1) << B));
        side_q[i] <= side_in;
      end
    end
  end

  assign valid_o = v_q[R_W-1];
  assign root_o  = root_q[R_W-1];
  assign side_o  = side_q[R_W-1];

endmodule

[hw/rtl/fresnel_reflectance.sv]
// Channel   Direction  Handshake           Payload
// input     in         valid_i / stall_o   in_i  (frl_pkg::frl_in_t)
// output    out        valid_o / stall_i   out_o (frl_pkg::frl_out_t)
//
// One transaction per cycle is sustained while the output is not stalled; every transaction
// travels from acceptance through the chain of bit-per-stage dividers and square roots.
// Reset clears only the valid bits of the pipeline and the skid stage.
// A stalled result parks in a skid register; stall_o is that register's valid bit,
// and the whole pipeline holds while it is occupied.
module fresnel_reflectance (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            stall_o,
  input  frl_pkg::frl_in_t  in_i,
  output logic            valid_o,
  input  logic            stall_i,
  output frl_pkg::frl_out_t out_o
);

  import frl_pkg::*;

  localparam int NW = FIELD_W;
  localparam int PW = 2 * NW;

  typedef struct packed {
    logic [COS_W-1:0] cosm;
    logic [NW-1:0]    n_out;
    logic [NW-1:0]    n_in;
    logic             sat;
  } d1_side_t;

  typedef struct packed {
    logic [NW-1:0]    rel;
    logic [NW-1:0]    n_out;
    logic [NW-1:0]    n_in;
    logic [COS_W-1:0] cosm;
    logic             tir;
  } mid_side_t;

  typedef struct packed {
    logic [NW-1:0] rel;
    logic          tir;
    logic          zero;
  } d3_side_t;

  logic en;
  assign en = !stall_o;

  // Stage A: component products, and zero indices replaced by one.
  logic                 a_v_q;
  logic signed [PW-1:0] px_q, py_q, pz_q;
  logic [NW-1:0]        obj_q, sur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q  <= PW'(in_i.normal_x * in_i.dir_x);
      py_q  <= PW'(in_i.normal_y * in_i.dir_y);
      pz_q  <= PW'(in_i.normal_z * in_i.dir_z);
      obj_q <= (in_i.index_object == '0) ? NW'(1) : in_i.index_object;
      sur_q <= (in_i.index_surround == '0) ? NW'(1) : in_i.index_surround;
    end
  end

  // Stage B: dot product, clamp, rounding to the cosine, and side selection.
  logic signed [PW+1:0] dot;
  logic [PW+1:0]        mag, magc;
  logic                 b_v_q;
  logic [COS_W-1:0]     b_cosm_q;
  logic [NW-1:0]        b_nout_q, b_nin_q;

  assign dot  = (PW+2)'(px_q) + (PW+2)'(py_q) + (PW+2)'(pz_q);
  assign mag  = dot[PW+1] ? (~dot + (PW+2)'(1)) : dot;
  assign magc = (mag > (PW+2)'(ONE2)) ? (PW+2)'(ONE2) : mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (en) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_cosm_q <= COS_W'((magc + ((PW+2)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
      b_nout_q <= dot[PW+1] ? sur_q : obj_q;
      b_nin_q  <= dot[PW+1] ? obj_q : sur_q;
    end
  end

  // Relative index division, saturated when the quotient exceeds 16 bits.
  localparam int D1N = NW + FRAC_BITS + 1;
  logic [D1N-1:0] d1_num;
  logic           d1_sat;
  d1_side_t       d1_side_in, d1_side_out;
  logic           d1_v;
  logic [NW-1:0]  d1_quot;

  assign d1_num = (D1N'(b_nin_q) << FRAC_BITS) + D1N'(b_nout_q >> 1);
  assign d1_sat = (D1N+1)'(d1_num) >= ((D1N+1)'(b_nout_q) << NW);
  assign d1_side_in = '{cosm: b_cosm_q, n_out: b_nout_q, n_in: b_nin_q, sat: d1_sat};

  frl_div #(
    .NUM_W (D1N),
    .DEN_W (NW),
    .Q_W   (NW),
    .SIDE_W($bits(d1_side_t))
  ) u_div_rel (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(b_v_q),
    .num_i  (d1_sat ? '0 : d1_num),
    .den_i  (b_nout_q),
    .side_i (d1_side_in),
    .valid_o(d1_v),
    .quot_o (d1_quot),
    .side_o (d1_side_out)
  );

  // Stage C: cosine squared, and the saturated relative index.
  logic                 c_v_q;
  mid_side_t            c_side_q;
  logic [2*COS_W-1:0]   c_csq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (en) begin
      c_v_q <= d1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_side_q <= '{rel:   d1_side_out.sat ? INDEX_MAX : d1_quot,
                    n_out: d1_side_out.n_out,
                    n_in:  d1_side_out.n_in,
                    cosm:  d1_side_out.cosm,
                    tir:   1'b0};
      c_csq_q  <= d1_side_out.cosm * d1_side_out.cosm;
    end
  end

  // Sine of incidence.
  logic             s1_v;
  logic [COS_W-1:0] sin_i;
  mid_side_t        s1_side;

  frl_sqrt #(
    .R_W   (COS_W),
    .SIDE_W($bits(mid_side_t))
  ) u_sqrt_sin (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(c_v_q),
    .arg_i  (ONE2 - (2*COS_W-1)'(c_csq_q)),
    .side_i (c_side_q),
    .valid_o(s1_v),
    .root_o (sin_i),
    .side_o (s1_side)
  );

  // Stage D: Snell numerator.
  localparam int D2N = NW + COS_W;
  logic           d_v_q;
  mid_side_t      d_side_q;
  logic [D2N-1:0] d_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
    end else if (en) begin
      d_v_q <= s1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_side_q <= s1_side;
      d_prod_q <= s1_side.n_out * sin_i;
    end
  end

  // Sine of transmission; total internal reflection when it would reach one.
  logic               d2_tir;
  mid_side_t          d2_side_in, d2_side_out;
  logic               d2_v;
  logic [FRAC_BITS-1:0] sin_t;

  assign d2_tir = d_prod_q >= (D2N'(d_side_q.n_in) << FRAC_BITS);
  always_comb begin
    d2_side_in     = d_side_q;
    d2_side_in.tir = d2_tir;
  end

  frl_div #(
    .NUM_W (D2N),
    .DEN_W (NW),
    .Q_W   (FRAC_BITS),
    .SIDE_W($bits(mid_side_t))
  ) u_div_sin (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(d_v_q),
    .num_i  (d2_tir ? '0 : d_prod_q),
    .den_i  (d_side_q.n_in),
    .side_i (d2_side_in),
    .valid_o(d2_v),
    .quot_o (sin_t),
    .side_o (d2_side_out)
  );

  // Stage E: sine of transmission squared.
  logic                   e_v_q;
  mid_side_t              e_side_q;
  logic [2*FRAC_BITS-1:0] e_ssq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q <= 1'b0;
    end else if (en) begin
      e_v_q <= d2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_side_q <= d2_side_out;
      e_ssq_q  <= sin_t * sin_t;
    end
  end

  logic             s2_v;
  logic [COS_W-1:0] cos_t;
  mid_side_t        s2_side;

  frl_sqrt #(
    .R_W   (COS_W),
    .SIDE_W($bits(mid_side_t))
  ) u_sqrt_cos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(e_v_q),
    .arg_i  (ONE2 - (2*COS_W-1)'(e_ssq_q)),
    .side_i (e_side_q),
    .valid_o(s2_v),
    .root_o (cos_t),
    .side_o (s2_side)
  );

  // Stage F: the four amplitude terms.
  logic           f_v_q;
  logic [NW-1:0]  f_rel_q;
  logic           f_tir_q;
  logic [D2N-1:0] f_x1_q, f_y1_q, f_x2_q, f_y2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else if (en) begin
      f_v_q <= s2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_rel_q <= s2_side.rel;
      f_tir_q <= s2_side.tir;
      f_x1_q  <= s2_side.n_in * s2_side.cosm;
      f_y1_q  <= s2_side.n_out * cos_t;
      f_x2_q  <= s2_side.n_out * s2_side.cosm;
      f_y2_q  <= s2_side.n_in * cos_t;
    end
  end

  // Stage G: sums and absolute differences.
  logic           g_v_q;
  logic [NW-1:0]  g_rel_q;
  logic           g_tir_q;
  logic [D2N:0]   g_den1_q, g_den2_q;
  logic [D2N-1:0] g_dif1_q, g_dif2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_v_q <= 1'b0;
    end else if (en) begin
      g_v_q <= f_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_rel_q  <= f_rel_q;
      g_tir_q  <= f_tir_q;
      g_den1_q <= (D2N+1)'(f_x1_q) + (D2N+1)'(f_y1_q);
      g_den2_q <= (D2N+1)'(f_x2_q) + (D2N+1)'(f_y2_q);
      g_dif1_q <= (f_x1_q >= f_y1_q) ? (f_x1_q - f_y1_q) : (f_y1_q - f_x1_q);
      g_dif2_q <= (f_x2_q >= f_y2_q) ? (f_x2_q - f_y2_q) : (f_y2_q - f_x2_q);
    end
  end

  // Both ratios in Q15, rounded half up.
  localparam int D3N = D2N + RATIO_BITS + 1;
  logic           z1, z2;
  logic [D3N-1:0] num1, num2;
  d3_side_t       d3_side_in, d3_side_out;
  logic           d3_v, d4_v, d4_zero;
  logic [NW-1:0]  r1, r2;

  assign z1   = (g_den1_q == '0);
  assign z2   = (g_den2_q == '0);
  assign num1 = (D3N'(g_dif1_q) << RATIO_BITS) + D3N'(g_den1_q >> 1);
  assign num2 = (D3N'(g_dif2_q) << RATIO_BITS) + D3N'(g_den2_q >> 1);
  assign d3_side_in = '{rel: g_rel_q, tir: g_tir_q, zero: z1};

  frl_div #(
    .NUM_W (D3N),
    .DEN_W (D2N + 1),
    .Q_W   (NW),
    .SIDE_W($bits(d3_side_t))
  ) u_div_r1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(g_v_q),
    .num_i  (z1 ? '0 : num1),
    .den_i  (g_den1_q),
    .side_i (d3_side_in),
    .valid_o(d3_v),
    .quot_o (r1),
    .side_o (d3_side_out)
  );

  frl_div #(
    .NUM_W (D3N),
    .DEN_W (D2N + 1),
    .Q_W   (NW),
    .SIDE_W(1)
  ) u_div_r2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(g_v_q),
    .num_i  (z2 ? '0 : num2),
    .den_i  (g_den2_q),
    .side_i (z2),
    .valid_o(d4_v),
    .quot_o (r2),
    .side_o (d4_zero)
  );

  // Stage H: squares of the ratios.
  logic          h_v_q;
  logic [NW-1:0] h_rel_q;
  logic          h_tir_q;
  logic [PW-1:0] h_sq1_q, h_sq2_q;
  logic [NW-1:0] q1, q2;

  assign q1 = d3_side_out.zero ? REFL_ONE : r1;
  assign q2 = d4_zero ? REFL_ONE : r2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_v_q <= 1'b0;
    end else if (en) begin
      h_v_q <= d3_v & d4_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_rel_q <= d3_side_out.rel;
      h_tir_q <= d3_side_out.tir;
      h_sq1_q <= q1 * q1;
      h_sq2_q <= q2 * q2;
    end
  end

  // Output register and skid stage.
  logic     out_v_q, skid_v_q;
  frl_out_t out_q, skid_q;
  logic [PW-1:0] refl_sum;

  assign refl_sum = h_sq1_q + h_sq2_q + (PW'(1) << RATIO_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= h_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.reflectance      <= h_tir_q ? REFL_ONE : refl_sum[PW-1:NW];
      out_q.relative_index   <= h_rel_q;
      out_q.total_reflection <= h_tir_q;
    end
  end

  // A result that is stalled while the pipeline moves on is parked here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else if (!skid_v_q) begin
      skid_v_q <= out_v_q & stall_i;
    end else if (!stall_i) begin
      skid_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_v_q) begin
      skid_q <= out_q;
    end
  end

  assign stall_o = skid_v_q;
  assign valid_o = skid_v_q | out_v_q;
  assign out_o   = skid_v_q ? skid_q : out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) stall_o |-> valid_o)
    else $error("skid stage occupied without a result on the output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && out_o.total_reflection) |-> (out_o.reflectance == REFL_ONE))
    else $error("total reflection without full reflectance");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (out_o.reflectance <= REFL_ONE))
    else $error("reflectance above one");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && stall_i) |=> (skid_v_q && $stable(skid_q)))
    else $error("parked transaction lost");

endmodule

[sim/fresnel_checker.sv]
module fresnel_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  frl_pkg::frl_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  frl_pkg::frl_out_t out_data_i,
  output int                errors_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import frl_pkg::*;

  localparam int F = FRAC_BITS;

  frl_out_t expected_q[$];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned amp_ratio(longint unsigned x, longint unsigned y);
    longint unsigned diff;
    longint unsigned den;
    diff = (x >= y) ? x - y : y - x;
    den = x + y;
    if (den == 0) return 64'd1 << 15;
    return ((diff << 15) + (den >> 1)) / den;
  endfunction

  function automatic frl_out_t fresnel_predict(frl_in_t t);
    longint dot;
    longint unsigned mag, cosm, n_out, n_in, obj, sur, rel, sin_i, sin_t, cos_t;
    longint unsigned q1, q2, one2;
    frl_out_t r;
    one2 = 64'd1 << (2 * F);
    dot = longint'(t.normal_x) * longint'(t.dir_x) + longint'(t.normal_y) * longint'(t.dir_y)
        + longint'(t.normal_z) * longint'(t.dir_z);
    mag = (dot < 0) ? longint'(-dot) : dot;
    if (mag > one2) mag = one2;
    cosm = (mag + (64'd1 << (F - 1))) >> F;
    obj = (t.index_object == 0) ? 1 : t.index_object;
    sur = (t.index_surround == 0) ? 1 : t.index_surround;
    // A negative cosine means the ray is entering the object.
    if (dot < 0) begin
      n_out = sur;
      n_in = obj;
    end else begin
      n_out = obj;
      n_in = sur;
    end
    rel = ((n_in << F) + (n_out >> 1)) / n_out;
    if (rel > 64'hFFFF) rel = 64'hFFFF;
    sin_i = int_sqrt(one2 - cosm * cosm);
    sin_t = (n_out * sin_i) / n_in;
    r.relative_index = rel[15:0];
    if (sin_t >= (64'd1 << F)) begin
      r.total_reflection = 1'b1;
      r.reflectance = REFL_ONE;
    end else begin
      cos_t = int_sqrt(one2 - sin_t * sin_t);
      q1 = amp_ratio(n_in * cosm, n_out * cos_t);
      q2 = amp_ratio(n_out * cosm, n_in * cos_t);
      r.total_reflection = 1'b0;
      r.reflectance = 16'((q1 * q1 + q2 * q2 + (64'd1 << 15)) >> 16);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors_o++;
  endtask

  initial errors_o = 0;
  assign pending_o = expected_q.size();

  always @(posedge clk_i) begin
    frl_out_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) expected_q.push_back(fresnel_predict(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_data_i.reflectance !== want.reflectance)
            report_mismatch("reflectance", out_data_i.reflectance, want.reflectance);
          if (out_data_i.relative_index !== want.relative_index)
            report_mismatch("relative_index", out_data_i.relative_index, want.relative_index);
          if (out_data_i.total_reflection !== want.total_reflection)
            report_mismatch("total_reflection", out_data_i.total_reflection,
                            want.total_reflection);
        end
      end
    end
  end
endmodule

[sim/fresnel_reflectance_tb.sv]
module fresnel_reflectance_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import frl_pkg::*;

  localparam int RANDOM_ITEMS = 1250;
  localparam int CYCLE_LIMIT = 400000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  frl_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  frl_out_t out_data;
  int       errors;
  int       pending;
  int       cycles = 0;
  bit       hold_off = 1'b0;

  frl_in_t  directed_q[$];

  always #2 clk = ~clk;

  fresnel_reflectance dut (
    .clk_i(clk), .rst_ni(rst_n), .valid_i(in_valid), .stall_o(in_stall), .in_i(in_data),
    .valid_o(out_valid), .stall_i(out_stall), .out_o(out_data)
  );

  fresnel_checker checker_u (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_i(in_stall),
    .in_data_i(in_data), .out_valid_i(out_valid), .out_stall_i(out_stall),
    .out_data_i(out_data), .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [15:0] rand_comp();
    return 16'($urandom_range(0, 32768)) - 16'd16384;
  endfunction

  // Mostly random components within plus or minus one, part of them aligned along x, with some full-range noise.
  function automatic frl_in_t random_hit();
    frl_in_t t;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      t.normal_x = rand_comp(); t.normal_y = rand_comp(); t.normal_z = rand_comp();
      t.dir_x = rand_comp(); t.dir_y = rand_comp(); t.dir_z = rand_comp();
      if (sel < 3) begin
        t.normal_y = 0; t.normal_z = 0; t.normal_x = 16384;
        t.dir_y = 0; t.dir_z = 0;
      end
      t.index_object = 16'($urandom_range(16384, 49151));
      t.index_surround = 16'($urandom_range(16384, 49151));
    end else begin
      t = frl_in_t'({$urandom, $urandom, $urandom, $urandom});
    end
    return t;
  endfunction

  // Valid drops only when there is an idle gap, so back to back transactions
  // never see two updates of valid in one time step.
  task automatic send_hit(frl_in_t t, int gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= t;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Receiver: random stall per transaction, plus one long hold-off on request.
  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    frl_in_t t;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    t = '0; t.normal_x = 16384; t.dir_x = -16384;
    t.index_object = 24576; t.index_surround = 16384;
    directed_q.push_back(t);                           // head-on entering
    t.dir_x = 16384; directed_q.push_back(t);          // head-on leaving
    t.dir_x = 0; t.dir_y = 16384; directed_q.push_back(t); // zero dot, grazing
    t = '0; t.normal_z = 16384; t.dir_z = 9000; t.dir_x = 13000;
    t.index_object = 49151; t.index_surround = 16384;
    directed_q.push_back(t);                           // total internal reflection
    t.index_object = 0; t.index_surround = 0; directed_q.push_back(t); // zero indices
    t.index_object = 0; t.index_surround = 49151; directed_q.push_back(t);
    t.index_object = 16'hFFFF; t.index_surround = 0; directed_q.push_back(t);
    t = '0; t.normal_x = 16'sh7FFF; t.normal_y = 16'sh7FFF; t.normal_z = 16'sh7FFF;
    t.dir_x = 16'sh8000; t.dir_y = 16'sh8000; t.dir_z = 16'sh8000;
    t.index_object = 16'hFFFF; t.index_surround = 16'hFFFF;
    directed_q.push_back(t);                           // non-unit, clamped
    t.dir_x = 16'sh7FFF; t.dir_y = 16'sh7FFF; t.dir_z = 16'sh7FFF; directed_q.push_back(t);
    t = '1; directed_q.push_back(t);
    t = '0; t.normal_x = 16384; t.dir_x = -11585; t.dir_y = 11585;
    t.index_object = 21845; t.index_surround = 16384;
    directed_q.push_back(t);                           // forty five degrees
    t.index_object = 16384; directed_q.push_back(t);   // matched indices
    foreach (directed_q[i]) send_hit(directed_q[i], $urandom_range(0, 10));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) hold_off = 1'b1;
      if (i >= RANDOM_ITEMS / 2 && i < RANDOM_ITEMS / 2 + 150) begin
        // Back to back during the hold-off so the pipeline fills.
        send_hit(random_hit(), 0);
      end else begin
        send_hit(random_hit(), $urandom_range(0, 10));
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

[fresnel_reflectance.f]
hw/rtl/frl_pkg.sv
hw/rtl/frl_div.sv
hw/rtl/frl_sqrt.sv
hw/rtl/fresnel_reflectance.sv
sim/fresnel_checker.sv
sim/fresnel_reflectance_tb.sv
